// File: rtl/bsrs_pkg.sv
package bsrs_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_ERASE    = 2'd1,
    FUNC_CONTAINS = 2'd2,
    FUNC_GET      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RANK
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] value;
    logic [7:0]  rank_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] item;
    logic [8:0]  count;
    logic        is_empty;
  } rsp_t;

  // Compare results on the word coming out of the store
  typedef struct packed {
    logic eq;     // word equals the search key
    logic below;  // word shares the rank prefix and has a zero at the probed bit
  } scan_flags_t;

endpackage

// File: rtl/bounded_set_with_rank_select.sv
// Bounded set of distinct items with rank select.
//
// Issue a request on req with start high; it is taken on an edge where start
// is high and busy is low. busy stays high while the request works. The
// result appears on rsp for exactly one cycle with done high; the receiver
// cannot stall it, so capture it in that cycle. busy is already low in the
// done cycle, so the next request may be taken there.
//
// Work per request (one store read per cycle, one read port):
//   insert, contains : one scan of the store
//   erase            : scan up to the match, then shift the later items down
//   get              : one scan per item bit (radix select from the top bit);
//                      no scan when the rank is not below the count.
//
// Reset clears the count and control; the item memory is not cleared, since
// only entries below the count are ever read.
module bounded_set_with_rank_select #(
  parameter int CAPACITY = 256,
  parameter int ITEM_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bsrs_pkg::req_t req,
  output logic           done,
  output bsrs_pkg::rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = (ITEM_BITS > 1) ? $clog2(ITEM_BITS) : 1;
  localparam int RW = (CW > 8) ? CW : 8;

  bsrs_pkg::state_e      state, state_next;
  bsrs_pkg::func_e       op;
  bsrs_pkg::scan_flags_t flags;

  logic [CW-1:0]        count;
  logic [CW-1:0]        ptr;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic                 hit;
  logic [AW-1:0]        pos;
  logic [ITEM_BITS-1:0] key;
  logic [ITEM_BITS-1:0] prefix;
  logic [ITEM_BITS-1:0] mask;
  logic [BW-1:0]        bit_idx;
  logic [CW-1:0]        r;
  logic [CW-1:0]        cnt;
  logic [ITEM_BITS-1:0] rdata;

  logic                 accept;
  logic                 issue;
  logic                 drained;
  logic                 search_end;
  logic                 rank_ok;
  logic                 room;
  logic                 take_one;
  logic [ITEM_BITS-1:0] prefix_fin;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ITEM_BITS-1:0] wr_data;

  function automatic bsrs_pkg::rsp_t make_rsp(input logic ok_in,
                                               input logic [31:0] item_in,
                                               input logic [CW-1:0] cnt_in);
    bsrs_pkg::rsp_t res;
    res.ok       = ok_in;
    res.item     = item_in;
    res.count    = 9'(cnt_in);
    res.is_empty = (cnt_in == '0);
    return res;
  endfunction

  assign busy       = (state != bsrs_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign rank_ok    = (RW'(req.rank_index) < RW'(count));
  assign drained    = (ptr >= count) && !pend;
  assign search_end = hit || drained;
  assign room       = (count < CW'(CAPACITY));
  // at the end of a rank pass, the probed bit is one when the rank lies past
  // the items that carry a zero there
  assign take_one   = !(r < cnt);
  assign prefix_fin = take_one ? (prefix | (ITEM_BITS'(1) << bit_idx)) : prefix;

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ptr[AW-1:0];
    wr_data    = key;
    unique case (state)
      bsrs_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.func == bsrs_pkg::FUNC_GET) begin
            state_next = rank_ok ? bsrs_pkg::ST_RANK : bsrs_pkg::ST_IDLE;
          end else begin
            state_next = bsrs_pkg::ST_SEARCH;
          end
        end
      end
      bsrs_pkg::ST_SEARCH: begin
        issue = !hit && (ptr < count);
        if (search_end) begin
          if (op == bsrs_pkg::FUNC_INSERT && !hit && room) begin
            wr_en   = 1'b1;
            wr_addr = count[AW-1:0];
            wr_data = key;
          end
          state_next = (op == bsrs_pkg::FUNC_ERASE && hit) ? bsrs_pkg::ST_SHIFT
                                                          : bsrs_pkg::ST_IDLE;
        end
      end
      bsrs_pkg::ST_SHIFT: begin
        // read j+1 while writing j: the two never meet on one entry
        issue = (ptr < count);
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - AW'(1);
          wr_data = rdata;
        end
        if (drained) begin
          state_next = bsrs_pkg::ST_IDLE;
        end
      end
      bsrs_pkg::ST_RANK: begin
        issue = (ptr < count);
        if (drained && bit_idx == '0) begin
          state_next = bsrs_pkg::ST_IDLE;
        end
      end
      default: state_next = bsrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      hit   <= 1'b0;
      ptr   <= '0;
    end else begin
      done     <= 1'b0;
      pend     <= issue;
      pend_idx <= ptr[AW-1:0];
      if (issue) begin
        ptr <= ptr + CW'(1);
      end
      unique case (state)
        bsrs_pkg::ST_IDLE: begin
          if (accept) begin
            op      <= req.func;
            key     <= ITEM_BITS'(req.value);
            ptr     <= '0;
            hit     <= 1'b0;
            cnt     <= '0;
            prefix  <= '0;
            mask    <= '0;
            bit_idx <= BW'(ITEM_BITS - 1);
            r       <= CW'(req.rank_index);
            if (req.func == bsrs_pkg::FUNC_GET && !rank_ok) begin
              done <= 1'b1;
              rsp  <= make_rsp(1'b0, '0, count);
            end
          end
        end
        bsrs_pkg::ST_SEARCH: begin
          if (pend && !hit && flags.eq) begin
            hit <= 1'b1;
            pos <= pend_idx;
          end
          if (search_end) begin
            case (op)
              bsrs_pkg::FUNC_INSERT: begin
                done <= 1'b1;
                if (!hit && room) begin
                  count <= count + CW'(1);
                  rsp   <= make_rsp(1'b1, '0, count + CW'(1));
                end else begin
                  rsp   <= make_rsp(1'b0, '0, count);
                end
              end
              bsrs_pkg::FUNC_ERASE: begin
                if (hit) begin
                  ptr <= CW'(pos) + CW'(1);
                end else begin
                  done <= 1'b1;
                  rsp  <= make_rsp(1'b0, '0, count);
                end
              end
              default: begin
                done <= 1'b1;
                rsp  <= make_rsp(hit, '0, count);
              end
            endcase
          end
        end
        bsrs_pkg::ST_SHIFT: begin
          if (drained) begin
            count <= count - CW'(1);
            done  <= 1'b1;
            rsp   <= make_rsp(1'b1, '0, count - CW'(1));
          end
        end
        bsrs_pkg::ST_RANK: begin
          if (pend && flags.below) begin
            cnt <= cnt + CW'(1);
          end
          if (drained) begin
            // settle this bit, then open the next pass one bit lower
            prefix           <= prefix_fin;
            mask[bit_idx]    <= 1'b1;
            if (take_one) begin
              r <= r - cnt;
            end
            cnt     <= '0;
            ptr     <= '0;
            bit_idx <= bit_idx - BW'(1);
            if (bit_idx == '0) begin
              done <= 1'b1;
              rsp  <= make_rsp(1'b1, 32'(prefix_fin), count);
            end
          end
        end
        default: ;
      endcase
    end
  end

  bsrs_store #(
    .DEPTH     (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr[AW-1:0]),
    .key     (key),
    .prefix  (prefix),
    .mask    (mask),
    .bit_sel (bit_idx),
    .rdata   (rdata),
    .flags   (flags)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still at work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("item count beyond capacity");

  a_item_only_get: assert property (@(posedge clk) disable iff (rst)
    (done && op != bsrs_pkg::FUNC_GET) |-> (rsp.item == '0))
    else $error("nonzero item on a result that is not a get");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.ok && op == bsrs_pkg::FUNC_INSERT) |-> (count == $past(count) + CW'(1)))
    else $error("successful insert did not grow the count by one");

endmodule

// File: rtl/bsrs_store.sv
module bsrs_store #(
  parameter int DEPTH = 256,
  parameter int ITEM_BITS = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int BW = (ITEM_BITS > 1) ? $clog2(ITEM_BITS) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [ITEM_BITS-1:0]   wr_data,
  input  logic [AW-1:0]          rd_addr,
  input  logic [ITEM_BITS-1:0]   key,
  input  logic [ITEM_BITS-1:0]   prefix,
  input  logic [ITEM_BITS-1:0]   mask,
  input  logic [BW-1:0]          bit_sel,
  output logic [ITEM_BITS-1:0]   rdata,
  output bsrs_pkg::scan_flags_t  flags
);

  logic [ITEM_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  assign flags.eq    = (rdata == key);
  assign flags.below = (((rdata ^ prefix) & mask) == '0) && !rdata[bit_sel];

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP = 256;

  // Tracks the set as the block should hold it and the results still owed.
  class set_tracker;
    logic [31:0]    store[SET_CAP];
    int             size;
    bsrs_pkg::rsp_t owed[$];
    int             mismatches;

    function new();
      size = 0;
      mismatches = 0;
    endfunction

    function int slot_of(logic [31:0] v);
      for (int p = 0; p < size; p++)
        if (store[p] == v) return p;
      return -1;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted beat to the set and queue the result it must give.
    function void note_request(bsrs_pkg::req_t r);
      bsrs_pkg::rsp_t e;
      int   pos;
      int   below;
      e = '0;
      pos = slot_of(r.value);
      case (r.func)
        bsrs_pkg::FUNC_INSERT: begin
          if (pos < 0 && size < SET_CAP) begin
            store[size] = r.value;
            size++;
            e.ok = 1'b1;
          end
        end
        bsrs_pkg::FUNC_ERASE: begin
          if (pos >= 0) begin
            for (int j = pos; j + 1 < size; j++) store[j] = store[j + 1];
            size--;
            e.ok = 1'b1;
          end
        end
        bsrs_pkg::FUNC_CONTAINS: e.ok = (pos >= 0);
        bsrs_pkg::FUNC_GET: begin
          if (int'(r.rank_index) < size) begin
            for (int j = 0; j < size; j++) begin
              below = 0;
              for (int k = 0; k < size; k++)
                if (store[j] > store[k]) below++;
              if (below == int'(r.rank_index)) begin
                e.item = store[j];
                e.ok = 1'b1;
                break;
              end
            end
          end
        end
      endcase
      e.count = 9'(size);
      e.is_empty = (size == 0);
      owed.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bsrs_pkg::rsp_t got);
      bsrs_pkg::rsp_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      compare_field("ok", 32'(want.ok), 32'(got.ok));
      compare_field("item", want.item, got.item);
      compare_field("count", 32'(want.count), 32'(got.count));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  bsrs_pkg::req_t req = '0;
  bsrs_pkg::rsp_t rsp;

  set_tracker  sb;
  logic [31:0] pool[16];

  bounded_set_with_rank_select u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // Raise start with the beat, wait until busy is low again, then record it.
  task automatic send_request(bsrs_pkg::func_e f, logic [31:0] v, logic [7:0] rk, int gap);
    bsrs_pkg::req_t r;
    r.func = f;
    r.value = v;
    r.rank_index = rk;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  // Drop start and hold until every owed result has come back or the wait bound runs out.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic random_op(int get_pct, int gap);
    bsrs_pkg::func_e f;
    logic [31:0]     v;
    logic [7:0]      rk;
    int              sel;
    if ($urandom_range(0, 99) < get_pct) f = bsrs_pkg::FUNC_GET;
    else f = bsrs_pkg::func_e'($urandom_range(0, 2));
    sel = $urandom_range(0, 9);
    if (sel < 6) v = pool[$urandom_range(0, 15)];
    else if (sel < 8 && sb.size > 0) v = sb.store[$urandom_range(0, sb.size - 1)];
    else v = $urandom;
    if ($urandom_range(0, 3) == 0) rk = 8'($urandom_range(0, 255));
    else rk = 8'($urandom_range(0, sb.size));
    send_request(f, v, rk, gap);
  endtask

  initial begin
    sb = new();
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h0000_0001;
    pool[3] = 32'h8000_0000;
    for (int i = 4; i < 16; i++) pool[i] = $urandom;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty set, duplicates, absent erase, rank edges, erase shifting.
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd0, pick_gap(0));
    send_request(bsrs_pkg::FUNC_CONTAINS, 32'h0, 8'hFF, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'h0, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'h0, 8'hFF, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'h5, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'h5, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'h8000_0000, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_CONTAINS, 32'h5, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_CONTAINS, 32'h7, 8'h00, pick_gap(0));
    for (int i = 0; i < 5; i++)
      send_request(bsrs_pkg::FUNC_GET, $urandom, 8'(i), pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd255, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'h0, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'h8000_0000, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'h7, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd0, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd1, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'hFFFF_FFFF, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, 32'h5, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd0, pick_gap(0));
    drain();

    // Random traffic on a small value pool so erase and contains hit often.
    for (int i = 0; i < 120; i++) random_op(20, pick_gap(((i / 30) % 3) == 1));
    drain();

    // Fill to capacity with random values.
    for (int i = 0; sb.size < SET_CAP; i++)
      send_request(bsrs_pkg::FUNC_INSERT, $urandom, 8'($urandom),
                   pick_gap(((i / 40) % 2) == 1));

    // At capacity: refused inserts, top ranks, erase from the middle and refill.
    send_request(bsrs_pkg::FUNC_INSERT, ~sb.store[0], 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, sb.store[255], 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd255, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd0, pick_gap(0));
    send_request(bsrs_pkg::FUNC_CONTAINS, sb.store[128], 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_ERASE, sb.store[100], 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd255, pick_gap(0));
    send_request(bsrs_pkg::FUNC_INSERT, 32'h1234_5678, 8'h00, pick_gap(0));
    send_request(bsrs_pkg::FUNC_GET, 32'h0, 8'd255, pick_gap(0));
    for (int i = 0; i < 30; i++) random_op(12, pick_gap(i >= 15));

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bsrs_pkg.sv
rtl/bsrs_store.sv
rtl/bounded_set_with_rank_select.sv
sim/tb.sv
